[design/bcc_pkg.sv]
// shared types and constants for the button click classifier
`default_nettype none

package bcc_pkg;

  // timestamp width inside the block (state registers and elapsed math)
  localparam int TIME_WIDTH_DEFAULT = 32;

  // field widths of the transactions
  localparam int NOW_WIDTH   = 32;
  localparam int EVENT_WIDTH = 2;
  localparam int CFG_WIDTH   = 16;

  // configuration port
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 3;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_DEBOUNCE     = 1'b0;
  localparam reg_idx_t REG_CLICK_WINDOW = 1'b1;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [CFG_WIDTH-1:0] CLICK_WINDOW_RESET = 16'd400;

  typedef logic [EVENT_WIDTH-1:0] click_event_t;
  localparam click_event_t EV_NONE   = 2'd0;
  localparam click_event_t EV_SINGLE = 2'd1;
  localparam click_event_t EV_DOUBLE = 2'd2;

endpackage

`default_nettype wire

[design/bcc_stream_if.sv]
// valid/ready stream interfaces for samples and click events
`default_nettype none

interface bcc_in_if
  import bcc_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 button_level;
  logic [NOW_WIDTH-1:0] now_ms;

  modport source (output valid, output button_level, output now_ms, input ready);
  modport sink (input valid, input button_level, input now_ms, output ready);
endinterface

interface bcc_out_if
  import bcc_pkg::*;
  ();
  logic         valid;
  logic         ready;
  click_event_t click_event;

  modport source (output valid, output click_event, input ready);
  modport sink (input valid, input click_event, output ready);
endinterface

`default_nettype wire

[design/button_click_classifier_core.sv]
// button click classifier: debounce, single click and double click detection
//
// Takes one button sample per transaction (pin level plus a free-running
// millisecond timestamp) and returns exactly one click event per sample:
// none, single click or double click. Throughput is one sample per clock
// unless the output stalls; samples pass through the input register, then
// the result register. The rate is set by the phase/timestamp state update
// on the registered sample. Both sides stall together: a sample moves into
// the result register only when that register is empty or being taken.
// debounce_ms (address 0x0) and click_window_ms (address 0x4) are 16-bit
// APB registers; the user must write them only while the block is idle,
// not enforced by the block. All time differences wrap modulo 2^TIME_WIDTH;
// the timestamp is truncated or zero-extended to TIME_WIDTH bits on entry.
`default_nettype none

module button_click_classifier_core
  import bcc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic      [APB_DATA_WIDTH-1:0] prdata,
  output logic                           pready,
  bcc_in_if.sink                         sample,
  bcc_out_if.source                      result
);

  // phase codes
  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_SINGLE   = 2'd2;
  localparam logic [1:0] PH_DOUBLE   = 2'd3;

  // configuration registers
  logic [CFG_WIDTH-1:0] debounce_ms;
  logic [CFG_WIDTH-1:0] click_window_ms;
  reg_idx_t             reg_idx;
  logic                 cfg_write;

  // input register
  logic                  s1_valid;
  logic                  s1_level;
  logic [TIME_WIDTH-1:0] s1_now;

  // classifier state
  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic [TIME_WIDTH-1:0] press_start;
  logic [TIME_WIDTH-1:0] press_start_next;
  logic [TIME_WIDTH-1:0] release_time;
  logic [TIME_WIDTH-1:0] release_time_next;
  click_event_t          ev_next;

  // result register
  logic         out_valid;
  click_event_t out_event;

  logic                  advance;
  logic                  fire;
  logic [TIME_WIDTH-1:0] since_press;
  logic [TIME_WIDTH-1:0] since_release;
  logic [TIME_WIDTH-1:0] debounce_w;
  logic [TIME_WIDTH-1:0] window_w;

  // ---------------------------------------------------------------- apb port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RESET;
      click_window_ms <= CLICK_WINDOW_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_DEBOUNCE:     debounce_ms     <= pwdata[CFG_WIDTH-1:0];
        REG_CLICK_WINDOW: click_window_ms <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:     prdata = APB_DATA_WIDTH'(debounce_ms);
      REG_CLICK_WINDOW: prdata = APB_DATA_WIDTH'(click_window_ms);
      default:          prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ flow control
  // pipeline moves when the result register is free or being drained
  assign advance      = !out_valid || result.ready;
  assign fire         = s1_valid && advance;
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s1_level <= sample.button_level;
      s1_now   <= TIME_WIDTH'(sample.now_ms);
    end
  end

  // -------------------------------------------------------- classifier logic
  // wrapping elapsed times against the latest press and the first release
  assign since_press   = s1_now - press_start;
  assign since_release = s1_now - release_time;
  assign debounce_w    = TIME_WIDTH'(debounce_ms);
  assign window_w      = TIME_WIDTH'(click_window_ms);

  always_comb begin
    phase_next        = phase;
    press_start_next  = press_start;
    release_time_next = release_time;
    ev_next           = EV_NONE;
    case (phase)
      PH_RELEASED: begin
        if (s1_level) begin
          phase_next       = PH_PRESSED;
          press_start_next = s1_now;
        end
      end
      PH_PRESSED: begin
        if (!s1_level) begin
          // a too-short press is dropped as bounce
          if (since_press < debounce_w) begin
            phase_next = PH_RELEASED;
          end else begin
            phase_next        = PH_SINGLE;
            release_time_next = s1_now;
          end
        end
      end
      PH_SINGLE: begin
        // window expiry wins over a late second press
        if (since_press > window_w) begin
          ev_next    = EV_SINGLE;
          phase_next = PH_RELEASED;
        end else if (s1_level && since_release > debounce_w) begin
          phase_next       = PH_DOUBLE;
          press_start_next = s1_now;
        end
      end
      default: begin
        // second press must be held past the debounce time
        if (!s1_level && since_press > debounce_w) begin
          ev_next    = EV_DOUBLE;
          phase_next = PH_RELEASED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_RELEASED;
      press_start  <= '0;
      release_time <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      press_start  <= press_start_next;
      release_time <= release_time_next;
    end
  end

  // ---------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_event <= ev_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.click_event = out_event;

  // --------------------------------------------------------------- assertions
  // any reported click returns the classifier to released
  a_event_releases: assert property (@(posedge clk) disable iff (rst)
    fire && ev_next != EV_NONE |=> phase == PH_RELEASED)
    else $error("click event did not return to released");

  // a single click only comes out of the single-click-seen phase
  a_single_phase: assert property (@(posedge clk) disable iff (rst)
    fire && ev_next == EV_SINGLE |-> phase == PH_SINGLE)
    else $error("single click outside single phase");

  // a double click only comes out of the second-press phase
  a_double_phase: assert property (@(posedge clk) disable iff (rst)
    fire && ev_next == EV_DOUBLE |-> phase == PH_DOUBLE)
    else $error("double click outside second press phase");

  // state only moves when a sample is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(phase) && $stable(press_start) && $stable(release_time))
    else $error("classifier state changed without a sample");

  // reserved event code never reaches the output
  a_no_reserved: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.click_event <= EV_DOUBLE)
    else $error("reserved click event code on output");

endmodule

`default_nettype wire
